@@ rtl/bfc_pkg.sv @@
// package for the brake light flash controller: mode codes, register indexes, reset values
`default_nettype none

package bfc_pkg;

    localparam int unsigned DataWidth = 8;
    localparam int unsigned ModeWidth = 3;
    localparam int unsigned CfgIndexWidth = 3;

    typedef logic [DataWidth-1:0] level_t;

    typedef enum logic [ModeWidth-1:0] {
        MODE_OFF       = 3'd0,
        MODE_FLASH_ON  = 3'd1,
        MODE_FLASH_OFF = 3'd2,
        MODE_STEADY    = 3'd3,
        MODE_LIGHTS    = 3'd4
    } mode_t;

    typedef enum logic [CfgIndexWidth-1:0] {
        CFG_STEP_DIVIDE  = 3'd0,
        CFG_BLINK_LIMIT  = 3'd1,
        CFG_HOLD_LIMIT   = 3'd2,
        CFG_LIGHTS_LEVEL = 3'd3,
        CFG_FULL_LEVEL   = 3'd4
    } cfg_index_t;

    localparam level_t StepDivideReset  = 8'd100;
    localparam level_t BlinkLimitReset  = 8'd30;
    localparam level_t HoldLimitReset   = 8'd100;
    localparam level_t LightsLevelReset = 8'd60;
    localparam level_t FullLevelReset   = 8'd255;
    localparam level_t DutyLevelReset   = 8'd60;

endpackage

`default_nettype wire

@@ rtl/brake_light_flash_controller_unit.sv @@
// top level: brake light flash controller with mode machine, pwm and output skid buffer
// accepted results are registered in the output register, or the skid one when stalled
// throughput: one tick per cycle while the skid register is empty; a two-entry buffer
// (output register plus skid register) takes one more tick while a result is stalled
// reset: synchronous active-low aresetn clears counters, mode and buffers and
// restores the configuration registers and duty level to their defaults
`default_nettype none

module brake_light_flash_controller_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [bfc_pkg::CfgIndexWidth-1:0] cfg_index,
    input  wire logic [bfc_pkg::DataWidth-1:0]     cfg_wdata,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_stop_switch,
    input  wire logic                              s_lights_switch,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_lamp_on,
    output logic [bfc_pkg::ModeWidth-1:0]          m_light_mode
);
    import bfc_pkg::*;

    level_t step_divide_reg, blink_limit_reg, hold_limit_reg;
    level_t lights_level_reg, full_level_reg;

    level_t tick_count_reg, tick_count_next;
    mode_t  mode_reg, mode_next;
    level_t blink_count_reg, blink_count_next;
    level_t hold_count_reg, hold_count_next;
    level_t duty_level_reg, duty_level_next;
    level_t pwm_phase_reg;

    logic                 out_valid_reg, skid_valid_reg;
    logic                 out_lamp_reg, skid_lamp_reg;
    logic [ModeWidth-1:0] out_mode_reg, skid_mode_reg;

    logic accept, step, lamp_next;

    assign accept  = s_valid && s_ready;
    assign s_ready = !skid_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_lamp_on = out_lamp_reg;
    assign m_light_mode = out_mode_reg;
    assign step = tick_count_reg > step_divide_reg;
    assign lamp_next = pwm_phase_reg < duty_level_next;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_divide_reg  <= StepDivideReset;
            blink_limit_reg  <= BlinkLimitReset;
            hold_limit_reg   <= HoldLimitReset;
            lights_level_reg <= LightsLevelReset;
            full_level_reg   <= FullLevelReset;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_STEP_DIVIDE:  step_divide_reg  <= cfg_wdata;
                CFG_BLINK_LIMIT:  blink_limit_reg  <= cfg_wdata;
                CFG_HOLD_LIMIT:   hold_limit_reg   <= cfg_wdata;
                CFG_LIGHTS_LEVEL: lights_level_reg <= cfg_wdata;
                CFG_FULL_LEVEL:   full_level_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // mode machine step
    always_comb begin
        tick_count_next  = tick_count_reg + 8'd1;
        mode_next        = mode_reg;
        blink_count_next = blink_count_reg;
        hold_count_next  = hold_count_reg;
        duty_level_next  = duty_level_reg;
        if (step) begin
            tick_count_next = '0;
            case (mode_reg)
                MODE_OFF: begin
                    duty_level_next = '0;
                    if (s_stop_switch) mode_next = MODE_FLASH_ON;
                    if (s_lights_switch) mode_next = MODE_LIGHTS;
                end
                MODE_FLASH_ON: begin
                    duty_level_next = full_level_reg;
                    blink_count_next = blink_count_reg + 8'd1;
                    if (blink_count_reg > blink_limit_reg) begin
                        blink_count_next = '0;
                        mode_next = MODE_FLASH_OFF;
                    end
                end
                MODE_FLASH_OFF: begin
                    duty_level_next = '0;
                    hold_count_next = hold_count_reg + 8'd1;
                    if (hold_count_reg > hold_limit_reg && s_stop_switch) begin
                        hold_count_next = '0;
                        mode_next = MODE_STEADY;
                    end
                    if (!s_stop_switch) begin
                        hold_count_next = '0;
                        mode_next = s_lights_switch ? MODE_LIGHTS : MODE_OFF;
                    end
                    // blink limit overrides the moves above
                    blink_count_next = blink_count_reg + 8'd1;
                    if (blink_count_reg > blink_limit_reg) begin
                        blink_count_next = '0;
                        mode_next = MODE_FLASH_ON;
                    end
                end
                MODE_STEADY: begin
                    duty_level_next = full_level_reg;
                    if (!s_stop_switch) mode_next = s_lights_switch ? MODE_LIGHTS : MODE_OFF;
                end
                MODE_LIGHTS: begin
                    duty_level_next = lights_level_reg;
                    if (s_stop_switch) mode_next = MODE_FLASH_ON;
                    if (!s_lights_switch) mode_next = MODE_OFF;
                end
                default: ;
            endcase
        end
    end

    // machine state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg  <= '0;
            mode_reg        <= MODE_OFF;
            blink_count_reg <= '0;
            hold_count_reg  <= '0;
            duty_level_reg  <= DutyLevelReset;
            pwm_phase_reg   <= '0;
        end else if (accept) begin
            tick_count_reg  <= tick_count_next;
            mode_reg        <= mode_next;
            blink_count_reg <= blink_count_next;
            hold_count_reg  <= hold_count_next;
            duty_level_reg  <= duty_level_next;
            pwm_phase_reg   <= pwm_phase_reg + 8'd1;
        end
    end

    // output register and skid register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= accept;
            end
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_lamp_reg <= skid_lamp_reg;
                out_mode_reg <= skid_mode_reg;
            end else begin
                out_lamp_reg <= lamp_next;
                out_mode_reg <= ModeWidth'(mode_next);
            end
        end else if (accept) begin
            skid_lamp_reg <= lamp_next;
            skid_mode_reg <= ModeWidth'(mode_next);
        end
    end

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a transaction while output register is empty");

    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted transaction produced no result");

    a_step_clears_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && step) |=> (tick_count_reg == '0))
        else $error("tick counter not cleared on machine step");

    a_stall_fills_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && m_valid && !m_ready) |=> !s_ready)
        else $error("stalled result not held in skid register");

endmodule

`default_nettype wire

@@ sim/bfc_lamp_checker.sv @@
// lamp checker: predicts each lamp transaction from the switch ticks and compares results
module bfc_lamp_checker
    import bfc_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_wr_en,
    input  wire logic [CfgIndexWidth-1:0] cfg_index,
    input  wire logic [DataWidth-1:0]     cfg_wdata,
    input  wire logic                     s_valid,
    input  wire logic                     s_ready,
    input  wire logic                     s_stop_switch,
    input  wire logic                     s_lights_switch,
    input  wire logic                     m_valid,
    input  wire logic                     m_ready,
    input  wire logic                     m_lamp_on,
    input  wire logic [ModeWidth-1:0]     m_light_mode,
    output int unsigned                   fail_count,
    output int unsigned                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned PrintCap = 40;

    typedef struct packed {
        logic  lamp_on;
        mode_t light_mode;
    } lamp_result_t;

    level_t step_divide, blink_limit, hold_limit, lights_level, full_level;
    level_t tick_count, blink_count, hold_count, duty_level, pwm_phase;
    mode_t  mode;

    lamp_result_t lamp_expect_q[$];
    int unsigned  mismatch_total = 0;

    assign fail_count = mismatch_total;

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (mismatch_total < PrintCap) begin
            $display("%0t ns lamp check: %s got %0d expected %0d", $realtime, what, got, want);
        end
        mismatch_total++;
    endtask

    task automatic predict_lamp(input logic stop, input logic lights, output lamp_result_t res);
        level_t prior;
        prior = tick_count;
        tick_count = prior + 8'd1;
        if (prior > step_divide) begin
            tick_count = '0;
            case (mode)
                MODE_OFF: begin
                    duty_level = '0;
                    if (stop) mode = MODE_FLASH_ON;
                    if (lights) mode = MODE_LIGHTS;
                end
                MODE_FLASH_ON: begin
                    duty_level = full_level;
                    prior = blink_count;
                    blink_count = prior + 8'd1;
                    if (prior > blink_limit) begin
                        blink_count = '0;
                        mode = MODE_FLASH_OFF;
                    end
                end
                MODE_FLASH_OFF: begin
                    duty_level = '0;
                    prior = hold_count;
                    hold_count = prior + 8'd1;
                    if (prior > hold_limit && stop) begin
                        hold_count = '0;
                        mode = MODE_STEADY;
                    end
                    if (!stop) begin
                        hold_count = '0;
                        mode = lights ? MODE_LIGHTS : MODE_OFF;
                    end
                    // blink rule is applied last and wins
                    prior = blink_count;
                    blink_count = prior + 8'd1;
                    if (prior > blink_limit) begin
                        blink_count = '0;
                        mode = MODE_FLASH_ON;
                    end
                end
                MODE_STEADY: begin
                    duty_level = full_level;
                    if (!stop) mode = lights ? MODE_LIGHTS : MODE_OFF;
                end
                MODE_LIGHTS: begin
                    duty_level = lights_level;
                    if (stop) mode = MODE_FLASH_ON;
                    if (!lights) mode = MODE_OFF;
                end
                default: begin
                end
            endcase
        end
        res.lamp_on = (pwm_phase < duty_level);
        res.light_mode = mode;
        pwm_phase = pwm_phase + 8'd1;
    endtask

    always @(posedge aclk) begin : watch
        lamp_result_t want;
        if (!aresetn) begin
            step_divide = StepDivideReset;
            blink_limit = BlinkLimitReset;
            hold_limit = HoldLimitReset;
            lights_level = LightsLevelReset;
            full_level = FullLevelReset;
            tick_count = '0;
            blink_count = '0;
            hold_count = '0;
            pwm_phase = '0;
            duty_level = DutyLevelReset;
            mode = MODE_OFF;
            lamp_expect_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (lamp_expect_q.size() == 0) begin
                    report_mismatch("transaction with nothing expected, mode", 8'(m_light_mode),
                                    8'd0);
                end else begin
                    want = lamp_expect_q.pop_front();
                    if (m_lamp_on !== want.lamp_on) begin
                        report_mismatch("lamp_on", 8'(m_lamp_on), 8'(want.lamp_on));
                    end
                    if (m_light_mode !== want.light_mode) begin
                        report_mismatch("light_mode", 8'(m_light_mode), 8'(want.light_mode));
                    end
                end
            end
            if (s_valid && s_ready) begin
                predict_lamp(s_stop_switch, s_lights_switch, want);
                lamp_expect_q.push_back(want);
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_STEP_DIVIDE:  step_divide = cfg_wdata;
                    CFG_BLINK_LIMIT:  blink_limit = cfg_wdata;
                    CFG_HOLD_LIMIT:   hold_limit = cfg_wdata;
                    CFG_LIGHTS_LEVEL: lights_level = cfg_wdata;
                    CFG_FULL_LEVEL:   full_level = cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
        pending <= lamp_expect_q.size();
    end

endmodule

@@ sim/tb.sv @@
// testbench top: drives switch ticks and register writes into the flash controller, gives verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bfc_pkg::*;

    localparam int unsigned CycleLimit  = 200_000;
    localparam int unsigned LongStall   = 60;
    localparam int unsigned CfgCount    = 5;
    localparam int unsigned CfgIndexTop = (1 << CfgIndexWidth) - 1;
    localparam int unsigned TailCycles  = 8;

    // {stop, lights} per tick
    localparam logic [1:0] DirectedTicks [24] = '{
        2'b00, 2'b00, 2'b10, 2'b10, 2'b10, 2'b10, 2'b10, 2'b10,
        2'b10, 2'b10, 2'b10, 2'b10, 2'b11, 2'b11, 2'b01, 2'b01,
        2'b01, 2'b01, 2'b11, 2'b11, 2'b01, 2'b00, 2'b00, 2'b10
    };

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic [CfgIndexWidth-1:0] cfg_index = '0;
    logic [DataWidth-1:0]     cfg_wdata = '0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic                     s_stop_switch = 1'b0;
    logic                     s_lights_switch = 1'b0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic                     m_lamp_on;
    logic [ModeWidth-1:0]     m_light_mode;

    logic        idle_on = 1'b1;
    logic        long_stall_req = 1'b0;
    int unsigned cycle_count = 0;
    int unsigned fail_count;
    int unsigned pending;

    brake_light_flash_controller_unit uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_stop_switch   (s_stop_switch),
        .s_lights_switch (s_lights_switch),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_lamp_on       (m_lamp_on),
        .m_light_mode    (m_light_mode)
    );

    bfc_lamp_checker lamp_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_stop_switch   (s_stop_switch),
        .s_lights_switch (s_lights_switch),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_lamp_on       (m_lamp_on),
        .m_light_mode    (m_light_mode),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : result_sink
        bit stall_done;
        stall_done = 1'b0;
        @(posedge aclk);
        forever begin
            if (long_stall_req && !stall_done) begin
                stall_done = 1'b1;
                m_ready <= 1'b0;
                repeat (LongStall) @(posedge aclk);
            end else if (idle_on && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge aclk);
            end
        end
    end

    task automatic send_tick(input logic stop, input logic lights);
        s_valid <= 1'b1;
        s_stop_switch <= stop;
        s_lights_switch <= lights;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [CfgIndexWidth-1:0] idx, input level_t value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    task automatic apply_config(input level_t step, input level_t blink, input level_t hold,
                                input level_t lights_lvl, input level_t full_lvl);
        logic [CfgIndexWidth-1:0] unused_idx;
        unused_idx = CfgIndexWidth'($urandom_range(CfgCount, CfgIndexTop));
        write_reg(CFG_STEP_DIVIDE, step);
        write_reg(CFG_BLINK_LIMIT, blink);
        write_reg(CFG_HOLD_LIMIT, hold);
        write_reg(CFG_LIGHTS_LEVEL, lights_lvl);
        write_reg(CFG_FULL_LEVEL, full_lvl);
        // writes past the register list must be ignored
        write_reg(unused_idx, level_t'($urandom_range(0, 255)));
        cfg_wr_en <= 1'b0;
    endtask

    // switches held in runs like a driver would, with occasional random noise ticks
    task automatic run_switches(input int unsigned count, input int unsigned flip_odds,
                                input int unsigned noise_odds);
        logic stop, lights;
        stop = 1'($urandom_range(0, 1));
        lights = 1'($urandom_range(0, 1));
        repeat (count) begin
            if ($urandom_range(0, flip_odds) == 0) stop = ~stop;
            if ($urandom_range(0, 3 * flip_odds) == 0) lights = ~lights;
            if ($urandom_range(0, noise_odds) == 0) begin
                send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
                send_tick(stop, lights);
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset configuration, long enough for one machine step
        run_switches(104, 30, 20);
        drain_results();

        apply_config(8'd0, 8'd0, 8'd0, 8'd255, 8'd128);
        foreach (DirectedTicks[i]) begin
            send_tick(DirectedTicks[i][1], DirectedTicks[i][0]);
        end
        drain_results();

        apply_config(8'd0, 8'd3, 8'd2, 8'd128, 8'd200);
        long_stall_req <= 1'b1;
        run_switches(50, 60, 30);
        drain_results();
        run_switches(50, 60, 30);
        drain_results();

        apply_config(8'd1, 8'd0, 8'd0, 8'd0, 8'd255);
        run_switches(70, 40, 25);
        drain_results();

        // divider at maximum: tick count wraps, machine never steps
        apply_config(8'd255, 8'd255, 8'd255, 8'd170, 8'd85);
        run_switches(260, 100, 50);
        drain_results();

        apply_config(8'd254, 8'd254, 8'd254, 8'd255, 8'd0);
        run_switches(30, 20, 10);
        drain_results();

        apply_config(level_t'($urandom_range(0, 3)), level_t'($urandom_range(0, 6)),
                     level_t'($urandom_range(0, 6)), level_t'($urandom_range(0, 255)),
                     level_t'($urandom_range(0, 255)));
        run_switches(50, 50, 30);
        drain_results();

        idle_on <= 1'b0;
        apply_config(level_t'($urandom_range(0, 3)), level_t'($urandom_range(0, 6)),
                     level_t'($urandom_range(0, 6)), level_t'($urandom_range(0, 255)),
                     level_t'($urandom_range(0, 255)));
        run_switches(50, 50, 30);
        drain_results();

        repeat (TailCycles) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
